// ===== src/tmma_pkg.sv =====
`timescale 1ns / 1ps

package tmma_pkg;

  // tile geometry
  localparam int TILE_EDGE  = 16;
  localparam int TILE_CELLS = TILE_EDGE * TILE_EDGE;
  localparam int IDX_W      = (TILE_EDGE > 1) ? $clog2(TILE_EDGE) : 1;
  localparam int ADDR_W     = (TILE_CELLS > 1) ? $clog2(TILE_CELLS) : 1;

  // field widths
  localparam int OP_W   = 3;
  localparam int POS_W  = 4;
  localparam int FAC_W  = 16;
  localparam int ACC_W  = 48;
  localparam int PROD_W = 2 * FAC_W;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WR_A = 3'd0,
    OP_WR_B = 3'd1,
    OP_WR_C = 3'd2,
    OP_MAC  = 3'd3,
    OP_RD_C = 3'd4
  } op_t;

  // tile store access bundle
  typedef struct packed {
    logic                    a_we;
    logic                    b_we;
    logic [ADDR_W-1:0]       ab_waddr;
    logic [FAC_W-1:0]        fac_wdata;
    logic                    c_we;
    logic [ADDR_W-1:0]       c_waddr;
    logic [ACC_W-1:0]        c_wdata;
    logic [ADDR_W-1:0]       a_raddr;
    logic [ADDR_W-1:0]       b_raddr;
    logic [ADDR_W-1:0]       c_raddr;
  } tile_req_t;

  // one mac step travelling down the pipe
  typedef struct packed {
    logic              vld;
    logic              first;
    logic              last;
    logic [ADDR_W-1:0] addr;
  } mac_tag_t;

  // accumulator write-back
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [ACC_W-1:0]  data;
  } c_wb_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    cell_addr = ADDR_W'(int'(r) * TILE_EDGE + int'(c));
  endfunction

  function automatic logic pos_in_tile(input logic [POS_W-1:0] p);
    pos_in_tile = int'(p) < TILE_EDGE;
  endfunction

endpackage

// ===== src/tmma_in_if.sv =====
`timescale 1ns / 1ps

interface tmma_in_if
  import tmma_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [POS_W-1:0]        row;
  logic [POS_W-1:0]        col;
  logic signed [FAC_W-1:0] factor_value;
  logic signed [ACC_W-1:0] acc_value;

  modport source (output valid, operation, row, col, factor_value, acc_value,
                  input ready);
  modport sink (input valid, operation, row, col, factor_value, acc_value,
                output ready);
endinterface

// ===== src/tmma_out_if.sv =====
`timescale 1ns / 1ps

interface tmma_out_if
  import tmma_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] read_value;
  logic                    overflow;

  modport source (output valid, read_value, overflow, input ready);
  modport sink (input valid, read_value, overflow, output ready);
endinterface

// ===== src/tiled_matrix_multiply_accumulate.sv =====
`timescale 1ns / 1ps
// one request at a time; each request gives exactly one response
// write requests: response registered from the request, kept in the hold register while the output is full
// read of C: response taken from the registered read of the accumulator memory
// multiply-accumulate: for active edge n, one product per cycle
// through the memory read, multiply and saturating add stages
// reset is synchronous: C reads as zero through per-entry written bits, no clearing pass

module tiled_matrix_multiply_accumulate
  import tmma_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  tmma_in_if.sink          in_chan,
  tmma_out_if.source       out_chan
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MAC   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_READ  = 5'b01000,
    ST_HOLD  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] active_r;
  logic [CFG_W-1:0] edge_n;
  logic [CFG_W-1:0] edge_last;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             rd_in_r, rd_in_nxt;
  logic             sticky_r;
  logic             out_vld_r, out_vld_nxt;
  logic [ACC_W-1:0] out_val_r, out_val_nxt;
  logic             out_ovf_r, out_ovf_nxt;
  logic [ACC_W-1:0] hold_r, hold_nxt;

  logic             accept;
  logic             out_free;
  logic             res_ev;
  logic [ACC_W-1:0] res_val;
  logic             in_range;
  logic [ADDR_W-1:0] in_addr;
  logic             k_end, j_end, i_end;

  tile_req_t        req;
  mac_tag_t         tag;
  c_wb_t            wb;
  logic             sat_hit;
  logic             mac_busy;
  logic [FAC_W-1:0] a_rdata;
  logic [FAC_W-1:0] b_rdata;
  logic [ACC_W-1:0] c_rdata;

  // active edge clipped to the tile
  assign edge_n    = (int'(active_r) > TILE_EDGE) ? CFG_W'(TILE_EDGE) : active_r;
  assign edge_last = edge_n - CFG_W'(1);

  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_vld_r || out_chan.ready;
  assign in_range = pos_in_tile(in_chan.row) && pos_in_tile(in_chan.col);
  assign in_addr  = cell_addr(IDX_W'(in_chan.row), IDX_W'(in_chan.col));

  assign k_end = CFG_W'(k_r) == edge_last;
  assign j_end = CFG_W'(j_r) == edge_last;
  assign i_end = CFG_W'(i_r) == edge_last;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_wr_en) begin
      active_r <= cfg_wr_data;
    end
  end

  // mac step issue
  always_comb begin
    tag.vld   = state_r == ST_MAC;
    tag.first = k_r == '0;
    tag.last  = k_end;
    tag.addr  = cell_addr(i_r, j_r);
  end

  // tile store access
  always_comb begin
    req.a_we      = accept && (in_chan.operation == OP_WR_A) && in_range;
    req.b_we      = accept && (in_chan.operation == OP_WR_B) && in_range;
    req.ab_waddr  = in_addr;
    req.fac_wdata = in_chan.factor_value;
    req.a_raddr   = cell_addr(i_r, k_r);
    req.b_raddr   = cell_addr(k_r, j_r);
    if (wb.we) begin
      req.c_we    = 1'b1;
      req.c_waddr = wb.addr;
      req.c_wdata = wb.data;
    end else begin
      req.c_we    = accept && (in_chan.operation == OP_WR_C) && in_range;
      req.c_waddr = in_addr;
      req.c_wdata = in_chan.acc_value;
    end
    req.c_raddr = (state_r == ST_MAC) ? tag.addr : in_addr;
  end

  // request sequencing
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    rd_in_nxt = rd_in_r;
    res_ev    = 1'b0;
    res_val   = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_chan.operation)
            OP_MAC: begin
              if (edge_n == '0) begin
                res_ev = 1'b1;
              end else begin
                state_nxt = ST_MAC;
                i_nxt     = '0;
                j_nxt     = '0;
                k_nxt     = '0;
              end
            end
            OP_RD_C: begin
              state_nxt = ST_READ;
              rd_in_nxt = in_range;
            end
            default: begin
              res_ev = 1'b1;
            end
          endcase
        end
      end
      ST_MAC: begin
        if (k_end) begin
          k_nxt = '0;
          if (j_end) begin
            j_nxt = '0;
            if (i_end) begin
              state_nxt = ST_DRAIN;
            end else begin
              i_nxt = i_r + IDX_W'(1);
            end
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          res_ev = 1'b1;
        end
      end
      ST_READ: begin
        res_ev  = 1'b1;
        res_val = rd_in_r ? c_rdata : '0;
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (res_ev) begin
      state_nxt = out_free ? ST_IDLE : ST_HOLD;
    end
  end

  // response register with a one-entry hold behind it
  always_comb begin
    out_vld_nxt = out_vld_r && !out_chan.ready;
    out_val_nxt = out_val_r;
    out_ovf_nxt = out_ovf_r;
    hold_nxt    = hold_r;
    if (res_ev) begin
      if (out_free) begin
        out_vld_nxt = 1'b1;
        out_val_nxt = res_val;
        out_ovf_nxt = sticky_r;
      end else begin
        hold_nxt = res_val;
      end
    end else if ((state_r == ST_HOLD) && out_free) begin
      out_vld_nxt = 1'b1;
      out_val_nxt = hold_r;
      out_ovf_nxt = sticky_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      sticky_r  <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
      rd_in_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      sticky_r  <= sticky_r || sat_hit;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      k_r       <= k_nxt;
      rd_in_r   <= rd_in_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_val_r <= out_val_nxt;
    out_ovf_r <= out_ovf_nxt;
    hold_r    <= hold_nxt;
  end

  assign in_chan.ready       = state_r == ST_IDLE;
  assign out_chan.valid      = out_vld_r;
  assign out_chan.read_value = out_val_r;
  assign out_chan.overflow   = out_ovf_r;

  tmma_tile_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .a_rdata (a_rdata),
    .b_rdata (b_rdata),
    .c_rdata (c_rdata)
  );

  tmma_mac_unit u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (tag),
    .a_rdata (a_rdata),
    .b_rdata (b_rdata),
    .c_rdata (c_rdata),
    .wb      (wb),
    .sat_hit (sat_hit),
    .busy    (mac_busy)
  );

`ifndef SYNTHESIS
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !mac_busy)
    else $error("request taken while mac pipe still busy");

  a_wb_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
    wb.we |-> (state_r == ST_MAC || state_r == ST_DRAIN))
    else $error("accumulator write-back outside multiply-accumulate");

  a_hold_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> out_vld_r)
    else $error("response held while output register empty");

  a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
    sticky_r |=> sticky_r)
    else $error("saturation flag cleared without reset");
`endif

endmodule

// ===== src/tmma_tile_store.sv =====
`timescale 1ns / 1ps

module tmma_tile_store
  import tmma_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  tile_req_t        req,
  output logic [FAC_W-1:0] a_rdata,
  output logic [FAC_W-1:0] b_rdata,
  output logic [ACC_W-1:0] c_rdata
);

  logic [FAC_W-1:0] mem_a [TILE_CELLS];
  logic [FAC_W-1:0] mem_b [TILE_CELLS];
  logic [ACC_W-1:0] mem_c [TILE_CELLS];

  logic [TILE_CELLS-1:0] c_vld_r;
  logic [TILE_CELLS-1:0] c_vld_nxt;
  logic                  c_rvld_r;
  logic [FAC_W-1:0]      a_q_r;
  logic [FAC_W-1:0]      b_q_r;
  logic [ACC_W-1:0]      c_q_r;

  // factor tiles, one write and one registered read each
  always_ff @(posedge clk) begin
    if (req.a_we) begin
      mem_a[req.ab_waddr] <= req.fac_wdata;
    end
    if (req.b_we) begin
      mem_b[req.ab_waddr] <= req.fac_wdata;
    end
    a_q_r <= mem_a[req.a_raddr];
    b_q_r <= mem_b[req.b_raddr];
  end

  // accumulator tile
  always_ff @(posedge clk) begin
    if (req.c_we) begin
      mem_c[req.c_waddr] <= req.c_wdata;
    end
    c_q_r <= mem_c[req.c_raddr];
  end

  // written marks, an unwritten entry reads as zero
  always_comb begin
    c_vld_nxt = c_vld_r;
    if (req.c_we) begin
      c_vld_nxt[req.c_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r  <= '0;
      c_rvld_r <= 1'b0;
    end else begin
      c_vld_r  <= c_vld_nxt;
      c_rvld_r <= c_vld_r[req.c_raddr];
    end
  end

  assign a_rdata = a_q_r;
  assign b_rdata = b_q_r;
  assign c_rdata = c_rvld_r ? c_q_r : '0;

endmodule

// ===== src/tmma_mac_unit.sv =====
`timescale 1ns / 1ps

module tmma_mac_unit
  import tmma_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  mac_tag_t         tag_in,
  input  logic [FAC_W-1:0] a_rdata,
  input  logic [FAC_W-1:0] b_rdata,
  input  logic [ACC_W-1:0] c_rdata,
  output c_wb_t            wb,
  output logic             sat_hit,
  output logic             busy
);

  mac_tag_t                 tag1_r;
  mac_tag_t                 tag2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic [ACC_W-1:0]         c_base_r;
  logic [ACC_W-1:0]         acc_r;
  logic [ACC_W-1:0]         acc_nxt;
  logic [ACC_W-1:0]         base;
  logic [ACC_W:0]           sum;
  logic                     ovf;

  // tag pipe follows memory latency then the product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
    end
  end

  // product stage
  assign prod_nxt = $signed(a_rdata) * $signed(b_rdata);

  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    c_base_r <= c_rdata;
  end

  // saturating accumulate, restart from the stored entry on the first step
  always_comb begin
    base = tag2_r.first ? c_base_r : acc_r;
    sum  = {base[ACC_W-1], base} + {{(ACC_W+1-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    ovf  = sum[ACC_W] != sum[ACC_W-1];
    if (ovf) begin
      acc_nxt = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_nxt = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (tag2_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  assign wb.we   = tag2_r.vld && tag2_r.last;
  assign wb.addr = tag2_r.addr;
  assign wb.data = acc_nxt;
  assign sat_hit = tag2_r.vld && ovf;
  assign busy    = tag1_r.vld || tag2_r.vld;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tmma_pkg::*;

  localparam int TOTAL_ITEMS    = 550;
  localparam int TAIL_ITEMS     = 40;
  localparam int BIG_MAC_MAX    = 6;
  localparam int MAX_REPORTS    = 10;
  localparam int TIMEOUT_CYCLES = 800_000;

  // spare operation codes, no effect on the tiles
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic signed [FAC_W-1:0] fac;
    logic signed [ACC_W-1:0] acc;
  } request_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] read_value;
    logic                    overflow;
  } response_t;

  typedef struct packed {
    request_t  req;
    logic      typed;
    response_t resp;
  } table_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  tmma_in_if  in_chan ();
  tmma_out_if out_chan ();

  tiled_matrix_multiply_accumulate i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .out_chan    (out_chan)
  );

  // shadow copy of the tiles and the sticky flag
  logic signed [FAC_W-1:0] a_tile [TILE_CELLS];
  logic signed [FAC_W-1:0] b_tile [TILE_CELLS];
  logic signed [ACC_W-1:0] c_tile [TILE_CELLS];
  bit                      a_loaded [TILE_CELLS];
  bit                      b_loaded [TILE_CELLS];
  logic                    sat_seen;
  logic [CFG_W-1:0]        edge_cfg;

  response_t  pending_resp [$];
  table_row_t dir_rows [$];

  int mismatches = 0;
  int sent_items = 0;
  int big_macs = 0;
  bit tx_quiet = 1'b0;
  bit tail_quiet = 1'b0;
  int rx_stall = 0;
  int rx_calm = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // edge actually used by the multiply-accumulate
  function automatic int mac_edge();
    return (int'(edge_cfg) > TILE_EDGE) ? TILE_EDGE : int'(edge_cfg);
  endfunction

  // c += a * b over the active square, saturating after every product
  function automatic void run_tile_mac();
    int n;
    logic signed [ACC_W+1:0] sum;
    n = mac_edge();
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        sum = c_tile[i * TILE_EDGE + j];
        for (int k = 0; k < n; k++) begin
          sum = sum + a_tile[i * TILE_EDGE + k] * b_tile[k * TILE_EDGE + j];
          if (sum > ACC_MAX) begin
            sum = ACC_MAX;
            sat_seen = 1'b1;
          end else if (sum < ACC_MIN) begin
            sum = ACC_MIN;
            sat_seen = 1'b1;
          end
        end
        c_tile[i * TILE_EDGE + j] = sum[ACC_W-1:0];
      end
    end
  endfunction

  // apply one request to the shadow tiles and return its response
  function automatic response_t predict_response(input request_t r);
    response_t rsp;
    int        idx;
    bit        in_tile;
    in_tile = int'(r.row) < TILE_EDGE && int'(r.col) < TILE_EDGE;
    idx = in_tile ? int'(r.row) * TILE_EDGE + int'(r.col) : 0;
    rsp.read_value = '0;
    case (r.op)
      OP_WR_A: begin
        if (in_tile) begin
          a_tile[idx] = r.fac;
          a_loaded[idx] = 1'b1;
        end
      end
      OP_WR_B: begin
        if (in_tile) begin
          b_tile[idx] = r.fac;
          b_loaded[idx] = 1'b1;
        end
      end
      OP_WR_C: begin
        if (in_tile) c_tile[idx] = r.acc;
      end
      OP_MAC: run_tile_mac();
      OP_RD_C: begin
        if (in_tile) rsp.read_value = c_tile[idx];
      end
      default: ;
    endcase
    rsp.overflow = sat_seen;
    return rsp;
  endfunction

  function automatic logic signed [FAC_W-1:0] rand_factor();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3: return '1;
      default: return FAC_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [ACC_W-1:0] rand_acc();
    int small_v;
    logic signed [ACC_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = ACC_MAX - ACC_W'($urandom_range(0, 1 << 20));
      1: v = ACC_MIN + ACC_W'($urandom_range(0, 1 << 20));
      2, 3: begin
        small_v = int'($urandom_range(0, 1 << 24)) - (1 << 23);
        v = ACC_W'(small_v);
      end
      default: v = ACC_W'({$urandom, $urandom});
    endcase
    return v;
  endfunction

  // mostly positions inside the active square, reads weighted up
  function automatic request_t random_request(input int n);
    request_t r;
    int       pick;
    r.fac = rand_factor();
    r.acc = rand_acc();
    if (n > 0 && $urandom_range(0, 4) != 0) begin
      r.row = POS_W'($urandom_range(0, n - 1));
      r.col = POS_W'($urandom_range(0, n - 1));
    end else begin
      r.row = POS_W'($urandom);
      r.col = POS_W'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 14) r.op = OP_WR_A;
    else if (pick < 28) r.op = OP_WR_B;
    else if (pick < 42) r.op = OP_WR_C;
    else if (pick < 54) r.op = OP_MAC;
    else if (pick < 95) r.op = OP_RD_C;
    else begin
      case ($urandom_range(0, 2))
        0: r.op = OP_SPARE_5;
        1: r.op = OP_SPARE_6;
        default: r.op = OP_SPARE_7;
      endcase
    end
    return r;
  endfunction

  // edge size per phase: small tiles first, then clipped and full edges, then mostly small
  function automatic logic [CFG_W-1:0] phase_edge(input int p);
    case (p)
      0: return CFG_W'(0);
      1: return CFG_W'(3);
      2: return CFG_W'(1);
      3: return CFG_W'(2);
      4: return CFG_W'(17);
      5: return CFG_W'(31);
      6: return CFG_W'(16);
      default: begin
        case ($urandom_range(0, 15))
          0: return CFG_W'(0);
          1: return CFG_W'($urandom_range(16, 31));
          default: return CFG_W'($urandom_range(1, 5));
        endcase
      end
    endcase
  endfunction

  function automatic void add_row(input logic [OP_W-1:0] op, input int row, input int col,
                                  input logic signed [FAC_W-1:0] fac,
                                  input logic signed [ACC_W-1:0] acc, input logic typed,
                                  input logic signed [ACC_W-1:0] rd, input logic ovf);
    table_row_t t;
    t.req.op = op;
    t.req.row = POS_W'(row);
    t.req.col = POS_W'(col);
    t.req.fac = fac;
    t.req.acc = acc;
    t.typed = typed;
    t.resp.read_value = rd;
    t.resp.overflow = ovf;
    dir_rows.push_back(t);
  endfunction

  // present one request, with an occasional idle burst in front of it
  task automatic issue_request(input request_t r, input logic typed, input response_t want);
    response_t rsp;
    if (!tx_quiet && !tail_quiet && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.operation    <= r.op;
    in_chan.row          <= r.row;
    in_chan.col          <= r.col;
    in_chan.factor_value <= r.fac;
    in_chan.acc_value    <= r.acc;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    rsp = predict_response(r);
    pending_resp.push_back(typed ? want : rsp);
    sent_items++;
  endtask

  // write every a and b element the next multiply-accumulate will read that is not loaded yet
  task automatic load_factors();
    int       n;
    request_t r;
    n = mac_edge();
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < n; k++) begin
        r.row = POS_W'(i);
        r.col = POS_W'(k);
        r.acc = rand_acc();
        if (!a_loaded[i * TILE_EDGE + k]) begin
          r.op = OP_WR_A;
          r.fac = rand_factor();
          issue_request(r, 1'b0, '0);
        end
        if (!b_loaded[i * TILE_EDGE + k]) begin
          r.op = OP_WR_B;
          r.fac = rand_factor();
          issue_request(r, 1'b0, '0);
        end
      end
    end
  endtask

  // one random request, factors loaded ahead of a multiply-accumulate
  task automatic send_random();
    request_t r;
    r = random_request(mac_edge());
    if (r.op == OP_MAC) begin
      // full-size passes are slow and the first needs a whole tile of loads
      if (mac_edge() > 8) begin
        if (big_macs >= BIG_MAC_MAX || (big_macs == 0 && sent_items > TOTAL_ITEMS / 2))
          r.op = OP_RD_C;
        else big_macs++;
      end
      if (r.op == OP_MAC) load_factors();
    end
    issue_request(r, 1'b0, '0);
  endtask

  // change the edge only once every response is back
  task automatic set_active_size(input logic [CFG_W-1:0] v);
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    edge_cfg = v;
  endtask

  // response side back-pressure: stall bursts and quiet stretches
  always @(posedge clk) begin
    if (tail_quiet || rx_calm > 0) begin
      if (rx_calm > 0) rx_calm--;
      out_chan.ready <= 1'b1;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_chan.ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          rx_stall = $urandom_range(0, 17);
          out_chan.ready <= 1'b0;
        end
        3: begin
          rx_calm = $urandom_range(30, 150);
          out_chan.ready <= 1'b1;
        end
        default: out_chan.ready <= 1'b1;
      endcase
    end
  end

  // compare each response with the oldest prediction
  always @(posedge clk) begin
    response_t got;
    response_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.read_value = out_chan.read_value;
      got.overflow = out_chan.overflow;
      if (pending_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: response with nothing pending: read_value %h overflow %b",
                   $realtime, got.read_value, got.overflow);
      end else begin
        want = pending_resp.pop_front();
        if (got.read_value !== want.read_value || got.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: expected read_value %h overflow %b, got %h %b",
                     $realtime, want.read_value, want.overflow, got.read_value,
                     got.overflow);
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 12);
    $display("status: fail");
    $finish;
  end

  initial begin
    int len;
    int phase;
    rst_n                <= 1'b0;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= ACTIVE_RESET;
    in_chan.valid        <= 1'b0;
    in_chan.operation    <= OP_RD_C;
    in_chan.row          <= '0;
    in_chan.col          <= '0;
    in_chan.factor_value <= '0;
    in_chan.acc_value    <= '0;
    for (int x = 0; x < TILE_CELLS; x++) begin
      a_tile[x] = '0;
      b_tile[x] = '0;
      c_tile[x] = '0;
      a_loaded[x] = 1'b0;
      b_loaded[x] = 1'b0;
    end
    sat_seen = 1'b0;
    edge_cfg = ACTIVE_RESET;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part on a one-element tile
    set_active_size(CFG_W'(1));
    add_row(OP_RD_C, 5, 5, '0, '0, 1'b1, '0, 1'b0);
    add_row(OP_RD_C, 15, 15, '0, '0, 1'b1, '0, 1'b0);
    add_row(OP_WR_C, 15, 15, '0, ACC_MIN, 1'b1, '0, 1'b0);
    add_row(OP_RD_C, 15, 15, '0, '0, 1'b1, ACC_MIN, 1'b0);
    add_row(OP_WR_A, 15, 15, 16'sh8000, '0, 1'b0, '0, 1'b0);
    add_row(OP_WR_B, 15, 15, 16'sh7FFF, '1, 1'b0, '0, 1'b0);
    add_row(OP_WR_A, 0, 0, 16'sh8000, '0, 1'b0, '0, 1'b0);
    add_row(OP_WR_B, 0, 0, 16'sh8000, '0, 1'b0, '0, 1'b0);
    add_row(OP_WR_C, 0, 0, '1, '0, 1'b1, '0, 1'b0);
    // row and column are don't-care on a multiply-accumulate
    add_row(OP_MAC, 7, 12, '0, '0, 1'b1, '0, 1'b0);
    add_row(OP_RD_C, 0, 0, '0, '0, 1'b1, 48'sh0000_4000_0000, 1'b0);
    add_row(OP_RD_C, 0, 1, '0, '0, 1'b1, '0, 1'b0);
    add_row(OP_SPARE_5, 3, 4, 16'sh7FFF, ACC_MAX, 1'b1, '0, 1'b0);
    add_row(OP_SPARE_6, 0, 0, '1, '1, 1'b1, '0, 1'b0);
    add_row(OP_SPARE_7, 15, 15, 16'sh8000, ACC_MIN, 1'b1, '0, 1'b0);
    // positive saturation sets the sticky flag
    add_row(OP_WR_C, 0, 0, '0, ACC_MAX, 1'b1, '0, 1'b0);
    add_row(OP_WR_A, 0, 0, 16'sh7FFF, '0, 1'b0, '0, 1'b0);
    add_row(OP_WR_B, 0, 0, 16'sh7FFF, '0, 1'b0, '0, 1'b0);
    add_row(OP_MAC, 0, 0, '0, '0, 1'b1, '0, 1'b1);
    add_row(OP_RD_C, 0, 0, '0, '0, 1'b1, ACC_MAX, 1'b1);
    // writing c leaves the flag alone
    add_row(OP_WR_C, 0, 0, '0, ACC_MIN + 48'sd5, 1'b1, '0, 1'b1);
    add_row(OP_WR_A, 0, 0, 16'sh8000, '0, 1'b0, '0, 1'b0);
    // negative saturation
    add_row(OP_MAC, 15, 0, '0, '0, 1'b1, '0, 1'b1);
    add_row(OP_RD_C, 0, 0, '0, '0, 1'b1, ACC_MIN, 1'b1);
    add_row(OP_RD_C, 15, 15, '0, '0, 1'b1, ACC_MIN, 1'b1);
    foreach (dir_rows[x]) issue_request(dir_rows[x].req, dir_rows[x].typed,
                                        dir_rows[x].resp);

    // random phases, one edge setting each
    phase = 0;
    while (sent_items < TOTAL_ITEMS - TAIL_ITEMS) begin
      set_active_size(phase_edge(phase));
      tx_quiet = ($urandom_range(0, 3) == 0);
      len = $urandom_range(15, 45);
      for (int x = 0; x < len && sent_items < TOTAL_ITEMS - TAIL_ITEMS; x++) begin
        send_random();
      end
      phase++;
    end

    // closing stretch with no idling on either side
    tail_quiet = 1'b1;
    for (int x = 0; x < TAIL_ITEMS; x++) begin
      send_random();
    end

    // drain and let the pipe settle
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_resp.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tmma_pkg.sv
src/tmma_in_if.sv
src/tmma_out_if.sv
src/tmma_tile_store.sv
src/tmma_mac_unit.sv
src/tiled_matrix_multiply_accumulate.sv
test/tb.sv
